/* rtl/sbfp_pkg.sv */
// Shared types, constants and helpers of the frame parser.
package sbfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 15;
    localparam int unsigned KIND_W = 3;

    localparam logic [BYTE_W-1:0] STX_FIRST  = 8'h4D;
    localparam logic [BYTE_W-1:0] STX_SECOND = 8'h46;
    localparam logic [BYTE_W-1:0] ETX_BYTE   = 8'h02;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 15'd244;
    localparam logic [LEN_W-1:0] TRAILER_BYTES     = 15'd2;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SECOND = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_BODY   = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_GOOD       = 3'd1,
        KIND_BAD_END    = 3'd2,
        KIND_BAD_CSUM   = 3'd3,
        KIND_LEN_REJECT = 3'd4
    } kind_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  frame_length;
    } result_t;

    function automatic logic [LEN_W-1:0] bcd_weight(
        input logic [BYTE_W-1:0] hi,
        input logic [BYTE_W-1:0] lo
    );
        logic [LEN_W-1:0] w;
        begin
            w = LEN_W'(hi[7:4]) * 15'd1000 + LEN_W'(hi[3:0]) * 15'd100
              + LEN_W'(lo[7:4]) * 15'd10 + LEN_W'(lo[3:0]);
            return w;
        end
    endfunction

endpackage

/* rtl/sbfp_parser_core.sv */
// Frame parser state machine, length decode, checksum and result word build.
module sbfp_parser_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [sbfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        cfg_wr_en,
    input  logic [sbfp_pkg::LEN_W-1:0]  cfg_wr_data,
    output sbfp_pkg::result_t           res
);

    sbfp_pkg::phase_t            phase_reg, phase_next;
    logic [sbfp_pkg::BYTE_W-1:0] len_high_reg, len_high_next;
    logic [sbfp_pkg::LEN_W-1:0]  payload_len_reg, payload_len_next;
    logic [sbfp_pkg::LEN_W-1:0]  remaining_reg, remaining_next;
    logic [sbfp_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [sbfp_pkg::BYTE_W-1:0] prev_byte_reg, prev_byte_next;
    logic [sbfp_pkg::LEN_W-1:0]  max_payload_reg;

    logic [sbfp_pkg::LEN_W-1:0]  len_dec;
    logic                        too_long;

    assign len_dec  = sbfp_pkg::bcd_weight(len_high_reg, rx_byte);
    assign too_long = len_dec > max_payload_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                sbfp_pkg::PH_SECOND:
                    phase_next = (rx_byte == sbfp_pkg::STX_SECOND) ? sbfp_pkg::PH_LEN_HI
                                                                   : sbfp_pkg::PH_HUNT;
                sbfp_pkg::PH_LEN_HI:
                    phase_next = sbfp_pkg::PH_LEN_LO;
                sbfp_pkg::PH_LEN_LO:
                    phase_next = too_long ? sbfp_pkg::PH_HUNT : sbfp_pkg::PH_BODY;
                sbfp_pkg::PH_BODY:
                    phase_next = (remaining_reg >= sbfp_pkg::TRAILER_BYTES) ? sbfp_pkg::PH_BODY
                                                                            : sbfp_pkg::PH_HUNT;
                default:
                    phase_next = (rx_byte == sbfp_pkg::STX_FIRST) ? sbfp_pkg::PH_SECOND
                                                                  : sbfp_pkg::PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        len_high_next    = len_high_reg;
        payload_len_next = payload_len_reg;
        remaining_next   = remaining_reg;
        xor_next         = xor_reg;
        prev_byte_next   = prev_byte_reg;
        res              = '0;
        res.kind         = sbfp_pkg::KIND_PAYLOAD;
        if (accept)
        begin
            prev_byte_next = rx_byte;
            unique case (phase_reg)
                sbfp_pkg::PH_SECOND:
                begin
                end
                sbfp_pkg::PH_LEN_HI:
                begin
                    len_high_next = rx_byte;
                    xor_next      = rx_byte;
                end
                sbfp_pkg::PH_LEN_LO:
                begin
                    payload_len_next = len_dec;
                    xor_next         = xor_reg ^ rx_byte;
                    if (too_long)
                    begin
                        res.valid        = 1'b1;
                        res.kind         = sbfp_pkg::KIND_LEN_REJECT;
                        res.frame_length = len_dec;
                    end
                    else
                    begin
                        remaining_next = len_dec + sbfp_pkg::TRAILER_BYTES;
                    end
                end
                sbfp_pkg::PH_BODY:
                begin
                    priority if (remaining_reg > sbfp_pkg::TRAILER_BYTES)
                    begin
                        xor_next       = xor_reg ^ rx_byte;
                        remaining_next = remaining_reg - 15'd1;
                        res.valid      = 1'b1;
                        res.kind       = sbfp_pkg::KIND_PAYLOAD;
                        res.data_byte  = rx_byte;
                    end
                    else if (remaining_reg == sbfp_pkg::TRAILER_BYTES)
                    begin
                        xor_next       = xor_reg ^ rx_byte;
                        remaining_next = 15'd1;
                    end
                    else
                    begin
                        remaining_next   = '0;
                        res.valid        = 1'b1;
                        res.frame_length = payload_len_reg;
                        priority if (prev_byte_reg != sbfp_pkg::ETX_BYTE)
                            res.kind = sbfp_pkg::KIND_BAD_END;
                        else if (xor_reg != rx_byte)
                            res.kind = sbfp_pkg::KIND_BAD_CSUM;
                        else
                            res.kind = sbfp_pkg::KIND_GOOD;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= sbfp_pkg::PH_HUNT;
            len_high_reg    <= '0;
            payload_len_reg <= '0;
            remaining_reg   <= '0;
            xor_reg         <= '0;
            prev_byte_reg   <= '0;
            max_payload_reg <= sbfp_pkg::MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            len_high_reg    <= len_high_next;
            payload_len_reg <= payload_len_next;
            remaining_reg   <= remaining_next;
            xor_reg         <= xor_next;
            prev_byte_reg   <= prev_byte_next;
            if (cfg_wr_en)
            begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

endmodule

/* rtl/sbfp_out_reg.sv */
// Result register between the parser and the output channel.
module sbfp_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  sbfp_pkg::result_t           res,
    input  logic                        out_stall,
    output logic                        busy,
    output logic                        out_valid,
    output logic [sbfp_pkg::KIND_W-1:0] kind,
    output logic [sbfp_pkg::BYTE_W-1:0] data_byte,
    output logic [sbfp_pkg::LEN_W-1:0]  frame_length
);

    logic                        valid_reg, valid_next;
    logic [sbfp_pkg::KIND_W-1:0] kind_reg;
    logic [sbfp_pkg::BYTE_W-1:0] data_reg;
    logic [sbfp_pkg::LEN_W-1:0]  len_reg;

    // hold while the word waits, otherwise take the next one
    assign busy       = valid_reg && out_stall;
    assign valid_next = load ? res.valid : busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data_byte;
            len_reg  <= res.frame_length;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign data_byte    = data_reg;
    assign frame_length = len_reg;

endmodule

/* rtl/stx_bcd_length_xor_frame_parser_unit.sv */
// A result word is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single result register is the only pacing element,
// and it stalls input only while a held word is itself stalled.
// Reset (rst_n, asynchronous, active low): hunt for first start byte, counters and
// checksum cleared, max_payload set to 244, output empty.
module stx_bcd_length_xor_frame_parser_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sbfp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        cfg_wr_en,
    input  logic [sbfp_pkg::LEN_W-1:0]  cfg_wr_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sbfp_pkg::KIND_W-1:0] kind,
    output logic [sbfp_pkg::BYTE_W-1:0] data_byte,
    output logic [sbfp_pkg::LEN_W-1:0]  frame_length
);

    sbfp_pkg::result_t res;
    logic              accept;
    logic              busy;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    sbfp_parser_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res)
    );

    sbfp_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .res          (res),
        .out_stall    (out_stall),
        .busy         (busy),
        .out_valid    (out_valid),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length)
    );

endmodule

/* tb/tb_stx_bcd_length_xor_frame_parser_unit.sv */
// Testbench for the frame parser: directed and random byte streams checked word by word.
`timescale 1ns / 100ps

module tb_stx_bcd_length_xor_frame_parser_unit;

    import sbfp_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_BYTES = 20;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } parser_word_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_SECOND,
        FAULT_END,
        FAULT_CSUM,
        FAULT_BOTH
    } fault_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  frame_length;

    logic [BYTE_W-1:0] bytes_to_send [$];
    parser_word_t      words_due [$];
    logic [BYTE_W-1:0] opening_bytes [0:24];

    int send_idle_pct = 14;
    int recv_idle_pct = 60;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int frame_bytes_queued = 0;
    int limit_now = MAX_PAYLOAD_RESET;

    // parser copy
    phase_t            ph;
    logic [BYTE_W-1:0] len_hi;
    logic [LEN_W-1:0]  pay_len;
    logic [LEN_W-1:0]  remaining;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] last_byte;
    logic [LEN_W-1:0]  len_limit;

    stx_bcd_length_xor_frame_parser_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int decode_len(input logic [7:0] hi, input logic [7:0] lo);
        return int'(hi[7:4]) * 1000 + int'(hi[3:0]) * 100 + int'(lo[7:4]) * 10
             + int'(lo[3:0]);
    endfunction

    function automatic logic [15:0] to_bcd(input int v);
        return {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic track_parser(input logic [BYTE_W-1:0] b);
        kind_t k;
        case (ph)
            PH_SECOND:
            begin
                if (b == STX_SECOND)
                    ph = PH_LEN_HI;
                else
                    ph = PH_HUNT;
            end
            PH_LEN_HI:
            begin
                len_hi = b;
                csum = b;
                ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                pay_len = LEN_W'(decode_len(len_hi, b));
                csum = csum ^ b;
                if (pay_len > len_limit)
                begin
                    words_due.push_back(parser_word_t'{KIND_LEN_REJECT, 8'h00, pay_len});
                    ph = PH_HUNT;
                end
                else
                begin
                    remaining = pay_len + 15'd2;
                    ph = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (remaining > 15'd2)
                begin
                    csum = csum ^ b;
                    remaining = remaining - 15'd1;
                    words_due.push_back(parser_word_t'{KIND_PAYLOAD, b, 15'd0});
                end
                else if (remaining == 15'd2)
                begin
                    csum = csum ^ b;
                    remaining = 15'd1;
                end
                else
                begin
                    if (last_byte != ETX_BYTE)
                        k = KIND_BAD_END;
                    else if (csum != b)
                        k = KIND_BAD_CSUM;
                    else
                        k = KIND_GOOD;
                    words_due.push_back(parser_word_t'{k, 8'h00, pay_len});
                    remaining = 15'd0;
                    ph = PH_HUNT;
                end
            end
            default:
            begin
                if (b == STX_FIRST)
                    ph = PH_SECOND;
                else
                    ph = PH_HUNT;
            end
        endcase
        last_byte = b;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (bytes_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= bytes_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        parser_word_t due;
        if (!rst_n)
        begin
            ph = PH_HUNT;
            len_hi = '0;
            pay_len = '0;
            remaining = '0;
            csum = '0;
            last_byte = '0;
            len_limit = MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (words_due.size() == 0)
                begin
                    report_mismatch("unexpected word, kind", int'(kind), -1);
                end
                else
                begin
                    due = words_due.pop_front();
                    if (kind !== due.kind)
                        report_mismatch("kind", int'(kind), int'(due.kind));
                    if (data_byte !== due.data)
                        report_mismatch("data_byte", int'(data_byte), int'(due.data));
                    if (frame_length !== due.len)
                        report_mismatch("frame_length", int'(frame_length), int'(due.len));
                end
            end
            if (in_valid && !in_stall)
                track_parser(rx_byte);
            if (cfg_wr_en)
                len_limit = cfg_wr_data;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (bytes_to_send.size() != 0 || in_valid || words_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= LEN_W'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_now = v;
    endtask

    task automatic queue_frame(input logic [7:0] hi, input logic [7:0] lo, input fault_t fault);
        logic [7:0] sum;
        logic [7:0] b;
        int n;
        n = decode_len(hi, lo);
        bytes_to_send.push_back(STX_FIRST);
        if (fault == FAULT_SECOND)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == STX_SECOND)
                b = STX_FIRST;
            bytes_to_send.push_back(b);
            frame_bytes_queued += 2;
            return;
        end
        bytes_to_send.push_back(STX_SECOND);
        bytes_to_send.push_back(hi);
        bytes_to_send.push_back(lo);
        sum = hi ^ lo;
        if (n > limit_now)
        begin
            frame_bytes_queued += 4;
            return;
        end
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            bytes_to_send.push_back(b);
        end
        b = ETX_BYTE;
        if (fault == FAULT_END || fault == FAULT_BOTH)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == ETX_BYTE)
                b = ~ETX_BYTE;
        end
        sum = sum ^ b;
        bytes_to_send.push_back(b);
        if (fault == FAULT_CSUM || fault == FAULT_BOTH)
            sum = sum ^ 8'($urandom_range(1, 255));
        bytes_to_send.push_back(sum);
        frame_bytes_queued += n + 6;
    endtask

    task automatic pick_length(output logic [7:0] hi, output logic [7:0] lo);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            hi = 8'h00;
            lo = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
        end
        else if (r < 85)
        begin
            hi = 8'($urandom_range(0, 255));
            lo = 8'($urandom_range(0, 255));
            if (decode_len(hi, lo) <= limit_now && decode_len(hi, lo) > 45)
            begin
                hi = 8'h00;
                lo = lo & 8'h3F;
            end
        end
        else if (r < 95 && limit_now < 9999)
        begin
            if (limit_now > 45)
                v = limit_now + 1;
            else
                v = limit_now + $urandom_range(0, 1);
            {hi, lo} = to_bcd(v);
        end
        else
        begin
            hi = 8'h00;
            lo = 8'h00;
        end
    endtask

    task automatic queue_random_bytes(input int target);
        logic [7:0] hi;
        logic [7:0] lo;
        int r;
        frame_bytes_queued = 0;
        while (frame_bytes_queued < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                bytes_to_send.push_back(8'($urandom_range(0, 255)));
                frame_bytes_queued += 1;
            end
            else
            begin
                pick_length(hi, lo);
                if (r < 20)
                    queue_frame(hi, lo, fault_t'($urandom_range(1, 4)));
                else
                    queue_frame(hi, lo, FAULT_NONE);
            end
        end
    endtask

    initial
    begin
        logic [15:0] edge_len;
        opening_bytes = '{
            STX_FIRST, STX_SECOND, 8'h00, 8'h01, 8'hFF, ETX_BYTE, 8'hFC,
            STX_FIRST, STX_FIRST, STX_FIRST, STX_SECOND, 8'h00, 8'h00, ETX_BYTE, 8'h00,
            STX_FIRST, STX_SECOND, 8'hFF, 8'hFF,
            STX_FIRST, STX_SECOND, 8'h00, 8'h00, 8'h05, 8'h55
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_bytes[i])
            bytes_to_send.push_back(opening_bytes[i]);
        edge_len = to_bcd(limit_now);
        queue_frame(edge_len[15:8], edge_len[7:0], FAULT_NONE);
        queue_random_bytes(RANDOM_BYTES);
        wait_idle();

        write_limit(0);
        queue_random_bytes(RANDOM_BYTES);
        wait_idle();

        send_idle_pct = 60;
        recv_idle_pct = 14;
        write_limit(37);
        queue_random_bytes(RANDOM_BYTES);
        wait_idle();

        write_limit(16665);
        queue_random_bytes(RANDOM_BYTES);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(32767);
        hold_requests++;
        queue_frame(8'h00, 8'h45, FAULT_NONE);
        queue_random_bytes(RANDOM_BYTES);
        wait_idle();

        repeat (10) @(posedge clk);
        if (words_due.size() != 0)
            report_mismatch("words never delivered", 0, words_due.size());
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
rtl/sbfp_pkg.sv
rtl/sbfp_parser_core.sv
rtl/sbfp_out_reg.sv
rtl/stx_bcd_length_xor_frame_parser_unit.sv
tb/tb_stx_bcd_length_xor_frame_parser_unit.sv
